[rtl/core/ksto_pkg.sv]
`default_nettype none

package ksto_pkg;

  localparam int SLOTS_DEFAULT = 8;

  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
  localparam logic [31:0] SEED_MUL   = 32'd1664525;
  localparam logic [31:0] SEED_ADD   = 32'd1013904223;
  localparam logic [31:0] WARP_MUL   = 32'd22695477;
  localparam logic [31:0] WARP_ADD   = 32'd1;

  typedef struct packed {
    logic capture;
    logic scan;
    logic commit;
    logic hash_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic miss;
    logic hash_done;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/keyed_slot_table_oldest_evict_core.sv]
// Sequence: a tick scans the key/age memories and then loads its result; a drive
// scans, commits, and on a miss runs the hash before its result loads. A result loads
// only while no held result is stalled; the next item is taken in the cycle after.
// The scan reads one entry per cycle; the hash is 14 steps on a shared 32x32 multiplier.
// Reset (rst, synchronous): all entries inactive, active count zero,
// no result pending; no clearing pass is needed.
`default_nettype none

module keyed_slot_table_oldest_evict_core #(
  parameter int SLOTS = ksto_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [31:0] key,
  input  logic [15:0] elapsed,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  slot,
  output logic        fresh,
  output logic [23:0] seed_frac,
  output logic [23:0] warp_frac,
  output logic [3:0]  active_count
);
  import ksto_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ksto_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ksto_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .key          (key),
    .elapsed      (elapsed),
    .cmd          (cmd),
    .sts          (sts),
    .slot         (slot),
    .fresh        (fresh),
    .seed_frac    (seed_frac),
    .warp_frac    (warp_frac),
    .active_count (active_count)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while previous item in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(rsp_valid && rsp_stall))
    else $error("held result overwritten");

  a_quiet_fracs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !fresh |-> (seed_frac == 24'd0) && (warp_frac == 24'd0))
    else $error("hash fractions nonzero without fresh claim");
`endif

endmodule

`default_nettype wire

[rtl/core/ksto_ctrl.sv]
`default_nettype none

module ksto_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ksto_pkg::cmd_t  cmd,
  input  ksto_pkg::sts_t  sts
);
  import ksto_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_HASH   = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.is_tick ? ST_OUT : ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sts.miss ? ST_HASH : ST_OUT;
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ksto_dp.sv]
`default_nettype none

module ksto_dp #(
  parameter int SLOTS = ksto_pkg::SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            action,
  input  logic [31:0]     key,
  input  logic [15:0]     elapsed,
  input  ksto_pkg::cmd_t  cmd,
  output ksto_pkg::sts_t  sts,
  output logic [2:0]      slot,
  output logic            fresh,
  output logic [23:0]     seed_frac,
  output logic [23:0]     warp_frac,
  output logic [3:0]      active_count
);
  import ksto_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] ISSUE_END = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

  localparam logic [3:0] HOP_SEED_MUL = 4'd0;
  localparam logic [3:0] HOP_SEED_ADD = 4'd1;
  localparam logic [3:0] HOP_SEED_X1  = 4'd2;
  localparam logic [3:0] HOP_SEED_MA  = 4'd3;
  localparam logic [3:0] HOP_SEED_X2  = 4'd4;
  localparam logic [3:0] HOP_SEED_MB  = 4'd5;
  localparam logic [3:0] HOP_SEED_X3  = 4'd6;
  localparam logic [3:0] HOP_WARP_MUL = 4'd7;
  localparam logic [3:0] HOP_WARP_ADD = 4'd8;
  localparam logic [3:0] HOP_WARP_X1  = 4'd9;
  localparam logic [3:0] HOP_WARP_MA  = 4'd10;
  localparam logic [3:0] HOP_WARP_X2  = 4'd11;
  localparam logic [3:0] HOP_WARP_MB  = 4'd12;
  localparam logic [3:0] HOP_WARP_X3  = 4'd13;

  logic [31:0]    key_mem [SLOTS];
  logic [31:0]    age_mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] driven;
  logic [CW-1:0]  count;

  logic           act_r;
  logic [31:0]    key_r;
  logic [15:0]    elap_r;

  logic [CW-1:0]  idx;
  logic           pend;
  logic [IW-1:0]  pidx;
  logic [31:0]    key_rd;
  logic [31:0]    age_rd;

  logic           hit;
  logic [IW-1:0]  hit_idx;
  logic           free;
  logic [IW-1:0]  free_idx;
  logic           have_best;
  logic [31:0]    best_age;
  logic [IW-1:0]  old_idx;

  logic [IW-1:0]  pick_r;
  logic           fresh_r;
  logic [23:0]    seed_r;
  logic [23:0]    warp_r;
  logic [31:0]    acc;
  logic [3:0]     hop;

  logic           issue;
  logic           proc;
  logic           p_valid;
  logic           p_driven;
  logic           retire;
  logic           age_keep;
  logic [32:0]    age_sum;
  logic [31:0]    age_sat;
  logic [IW-1:0]  pick;
  logic           claim;
  logic           age_we;
  logic [IW-1:0]  age_wa;
  logic [31:0]    age_wd;
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [31:0]    prod;
  logic [31:0]    hnext;
  logic [IW+2:0]  pick_ext;
  logic [CW+3:0]  cnt_ext;

  assign issue    = cmd.scan && (idx != ISSUE_END);
  assign proc     = cmd.scan && pend;
  assign p_valid  = valid[pidx];
  assign p_driven = driven[pidx];
  assign retire   = proc && act_r && p_valid && !p_driven;
  assign age_keep = proc && act_r && p_valid && p_driven;
  assign age_sum  = {1'b0, age_rd} + {17'b0, elap_r};
  assign age_sat  = age_sum[32] ? '1 : age_sum[31:0];
  assign pick     = hit ? hit_idx : (free ? free_idx : old_idx);
  assign claim    = cmd.commit && !hit;
  assign age_we   = claim || age_keep;
  assign age_wa   = claim ? pick : pidx;
  assign age_wd   = claim ? 32'd0 : age_sat;
  assign prod     = mul_a * mul_b;
  assign pick_ext = {3'b000, pick_r};
  assign cnt_ext  = {4'b0000, count};

  assign sts.is_tick   = act_r;
  assign sts.scan_done = proc && (pidx == LAST_IDX);
  assign sts.miss      = !hit;
  assign sts.hash_done = cmd.hash_step && (hop == HOP_WARP_X3);

  always_comb begin
    mul_a = acc;
    mul_b = HASH_MUL_A;
    hnext = acc;
    unique case (hop)
      HOP_SEED_MUL: begin
        mul_a = key_r;
        mul_b = SEED_MUL;
        hnext = prod;
      end
      HOP_WARP_MUL: begin
        mul_a = key_r;
        mul_b = WARP_MUL;
        hnext = prod;
      end
      HOP_SEED_ADD: begin
        hnext = acc + SEED_ADD;
      end
      HOP_WARP_ADD: begin
        hnext = acc + WARP_ADD;
      end
      HOP_SEED_X1, HOP_SEED_X3, HOP_WARP_X1, HOP_WARP_X3: begin
        hnext = acc ^ (acc >> 16);
      end
      HOP_SEED_X2, HOP_WARP_X2: begin
        hnext = acc ^ (acc >> 15);
      end
      HOP_SEED_MA, HOP_WARP_MA: begin
        mul_b = HASH_MUL_A;
        hnext = prod;
      end
      HOP_SEED_MB, HOP_WARP_MB: begin
        mul_b = HASH_MUL_B;
        hnext = prod;
      end
      default: begin
        hnext = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      key_mem[pick] <= key_r;
    end
    if (age_we) begin
      age_mem[age_wa] <= age_wd;
    end
    if (issue) begin
      key_rd <= key_mem[idx[IW-1:0]];
      age_rd <= age_mem[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      if (retire) begin
        valid[pidx] <= 1'b0;
        count       <= count - 1'b1;
      end else if (claim) begin
        valid[pick] <= 1'b1;
        if (!valid[pick]) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pidx <= idx[IW-1:0];
    end
    if (cmd.capture) begin
      act_r     <= action;
      key_r     <= key;
      elap_r    <= elapsed;
      hit       <= 1'b0;
      free      <= 1'b0;
      have_best <= 1'b0;
      fresh_r   <= 1'b0;
      pick_r    <= '0;
      seed_r    <= '0;
      warp_r    <= '0;
    end
    if (proc && !act_r) begin
      if (p_valid && (key_rd == key_r) && !hit) begin
        hit     <= 1'b1;
        hit_idx <= pidx;
      end
      if (!p_valid && !free) begin
        free     <= 1'b1;
        free_idx <= pidx;
      end
      if (p_valid && (!have_best || (age_rd > best_age))) begin
        have_best <= 1'b1;
        best_age  <= age_rd;
        old_idx   <= pidx;
      end
    end
    if (age_keep) begin
      driven[pidx] <= 1'b0;
    end
    if (cmd.commit) begin
      driven[pick] <= 1'b1;
      pick_r       <= pick;
      fresh_r      <= !hit;
      hop          <= HOP_SEED_MUL;
    end
    if (cmd.hash_step) begin
      acc <= hnext;
      hop <= hop + 4'd1;
      if (hop == HOP_SEED_X3) begin
        seed_r <= hnext[23:0];
      end
      if (hop == HOP_WARP_X3) begin
        warp_r <= hnext[23:0];
      end
    end
    if (cmd.out_load) begin
      slot         <= pick_ext[2:0];
      fresh        <= fresh_r;
      seed_frac    <= seed_r;
      warp_frac    <= warp_r;
      active_count <= cnt_ext[3:0];
    end
  end

endmodule

`default_nettype wire

[verif/keyed_slot_table_oldest_evict_core_tb.sv]
`timescale 1ns / 100ps

module keyed_slot_table_oldest_evict_core_tb;
  import ksto_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;
  localparam int POOL = 12;
  localparam int NUM_RANDOM = 1780;
  localparam int SAT_TICKS = 16;
  localparam int LONG_HOLD_AT = 700;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 4 * (SLOTS + 19);

  typedef enum logic {
    ACT_DRIVE = 1'b0,
    ACT_TICK  = 1'b1
  } act_e;

  typedef struct packed {
    act_e        act;
    logic [31:0] id;
    logic [15:0] ticks;
  } table_item_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        fresh;
    logic [23:0] seed;
    logic [23:0] warp;
    logic [3:0]  count;
  } table_result_t;

  typedef struct {
    table_item_t item;
    int unsigned gap;
    bit          drain;
  } queued_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        action = 1'b0;
  logic [31:0] key = '0;
  logic [15:0] elapsed = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [2:0]  slot;
  logic        fresh;
  logic [23:0] seed_frac;
  logic [23:0] warp_frac;
  logic [3:0]  active_count;

  keyed_slot_table_oldest_evict_core #(.SLOTS(SLOTS)) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action(action),
    .key(key),
    .elapsed(elapsed),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .slot(slot),
    .fresh(fresh),
    .seed_frac(seed_frac),
    .warp_frac(warp_frac),
    .active_count(active_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit          live [SLOTS];
  logic [31:0] tag [SLOTS];
  logic [31:0] age [SLOTS];
  bit          driven [SLOTS];

  queued_item_t  queued_items [$];
  table_result_t pending_results [$];
  bit            drain_next = 1'b0;

  int ops_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int calm_from = 32'h7FFF_FFFF;
  int n_hits = 0;
  int n_claims = 0;
  int n_evicts = 0;
  int n_ticks = 0;
  int n_clamps = 0;
  bit req_fire = 1'b0;

  function automatic logic [23:0] frac_hash(logic [31:0] n);
    n = n ^ (n >> 16);
    n = n * HASH_MUL_A;
    n = n ^ (n >> 15);
    n = n * HASH_MUL_B;
    n = n ^ (n >> 16);
    return n[23:0];
  endfunction

  function automatic table_result_t next_table_result(table_item_t it);
    table_result_t r;
    int i;
    int pick;
    int oldest;
    int cnt;
    r = '0;
    pick = -1;
    cnt = 0;
    if (it.act == ACT_DRIVE) begin
      for (i = 0; i < SLOTS; i++) begin
        if (pick < 0 && live[i] && tag[i] == it.id) pick = i;
      end
      if (pick >= 0) begin
        n_hits++;
      end else begin
        for (i = 0; i < SLOTS; i++) begin
          if (pick < 0 && !live[i]) pick = i;
        end
        if (pick < 0) begin
          oldest = 0;
          for (i = 1; i < SLOTS; i++) begin
            if (age[i] > age[oldest]) oldest = i;
          end
          pick = oldest;
          n_evicts++;
        end
        live[pick] = 1'b1;
        tag[pick] = it.id;
        age[pick] = '0;
        r.fresh = 1'b1;
        r.seed = frac_hash(it.id * SEED_MUL + SEED_ADD);
        r.warp = frac_hash(it.id * WARP_MUL + WARP_ADD);
        n_claims++;
      end
      driven[pick] = 1'b1;
      r.slot = 3'(pick);
    end else begin
      n_ticks++;
      for (i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (!driven[i]) begin
            live[i] = 1'b0;
          end else begin
            driven[i] = 1'b0;
            if (age[i] > AGE_MAX - 32'(it.ticks)) begin
              age[i] = AGE_MAX;
              n_clamps++;
            end else begin
              age[i] = age[i] + 32'(it.ticks);
            end
          end
        end
      end
    end
    for (i = 0; i < SLOTS; i++) cnt += live[i];
    r.count = 4'(cnt);
    return r;
  endfunction

  task automatic queue_op(act_e act, logic [31:0] id, logic [15:0] ticks, int unsigned gap);
    queued_item_t q;
    q.item.act = act;
    q.item.id = id;
    q.item.ticks = ticks;
    q.gap = gap;
    q.drain = drain_next;
    drain_next = 1'b0;
    queued_items.insert(queued_items.size(), q);
  endtask

  function automatic int unsigned pick_gap(bit busy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (busy || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (queued_items.size() == 0) begin
        req_valid <= 1'b0;
      end else if (gap_left < queued_items[0].gap) begin
        req_valid <= 1'b0;
        gap_left <= gap_left + 1;
      end else if (queued_items[0].drain && pending_results.size() != 0) begin
        req_valid <= 1'b0;
      end else begin
        action <= queued_items[0].item.act;
        key <= queued_items[0].item.id;
        elapsed <= queued_items[0].item.ticks;
        req_valid <= 1'b1;
        gap_left <= 0;
        queued_items.delete(0);
      end
    end
  end

  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned rsp_roll;
  bit long_hold_done = 1'b0;

  always @(negedge clk) begin
    rsp_roll = $urandom_range(0, 99);
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (!long_hold_done && ops_accepted >= LONG_HOLD_AT) begin
      rsp_stall <= 1'b1;
      stall_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (ops_accepted >= calm_from) begin
      rsp_stall <= 1'b0;
    end else if (calm_left != 0) begin
      rsp_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else if (rsp_roll < 60) begin
      rsp_stall <= 1'b0;
    end else if (rsp_roll < 85) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else if (rsp_roll < 88) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(10, 40);
    end else if (rsp_roll < 93) begin
      rsp_stall <= 1'b0;
      calm_left <= $urandom_range(50, 150);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    table_item_t   got_item;
    table_result_t want;
    if (rst) begin
      req_fire <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        live[i] = 1'b0;
        tag[i] = '0;
        age[i] = '0;
        driven[i] = 1'b0;
      end
    end else begin
      req_fire <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: slot %0d fresh %0d count %0d",
                 slot, fresh, active_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            mismatches++;
          end
          if (fresh !== want.fresh) begin
            $error("fresh: expected %0d, got %0d", want.fresh, fresh);
            mismatches++;
          end
          if (seed_frac !== want.seed) begin
            $error("seed_frac: expected 0x%06h, got 0x%06h", want.seed, seed_frac);
            mismatches++;
          end
          if (warp_frac !== want.warp) begin
            $error("warp_frac: expected 0x%06h, got 0x%06h", want.warp, warp_frac);
            mismatches++;
          end
          if (active_count !== want.count) begin
            $error("active_count: expected %0d, got %0d", want.count, active_count);
            mismatches++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        got_item.act = act_e'(action);
        got_item.id = key;
        got_item.ticks = elapsed;
        pending_results.insert(pending_results.size(), next_table_result(got_item));
        ops_accepted++;
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("keyed_slot_table_oldest_evict_core_tb NOT OK");
    $finish;
  end

  logic [31:0] key_pool [POOL];

  initial begin
    int n;
    int style;
    int random_sent;
    bit busy;
    logic [31:0] k;
    logic [31:0] sat_key;

    // empty table, extremes, repeat hit, fill, tie eviction, oldest eviction
    queue_op(ACT_TICK, 32'h0, 16'h0000, 0);
    queue_op(ACT_DRIVE, 32'h0000_0000, 16'hFFFF, 0);
    queue_op(ACT_DRIVE, 32'hFFFF_FFFF, 16'h0000, 0);
    queue_op(ACT_DRIVE, 32'h0000_0000, 16'h1234, 1);
    queue_op(ACT_DRIVE, 32'h8000_0000, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'h5555_5555, 16'h0, 2);
    queue_op(ACT_DRIVE, 32'hAAAA_AAAA, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'h0000_0001, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'h0000_0002, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'h0000_0003, 16'h0, 0);
    queue_op(ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, 0);
    queue_op(ACT_DRIVE, 32'h0000_0000, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'h0000_0004, 16'h0, 0);
    queue_op(ACT_DRIVE, 32'hFFFF_FFFF, 16'h0, 0);
    queue_op(ACT_TICK, 32'h0, 16'h0001, 3);
    for (int i = 5; i <= 11; i++) queue_op(ACT_DRIVE, 32'(i), 16'h0, 0);
    queue_op(ACT_TICK, 32'h0, 16'h0002, 0);

    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
    random_sent = 0;
    while (random_sent < NUM_RANDOM) begin
      busy = ($urandom_range(0, 9) < 3);
      style = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, POOL - 1)] = $urandom;
      if ($urandom_range(0, 49) == 0 ||
          (random_sent >= NUM_RANDOM / 2 && random_sent < NUM_RANDOM / 2 + 12)) begin
        drain_next = 1'b1;
      end
      if (style < 80) begin
        n = $urandom_range(0, 11);
        repeat (n) begin
          k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)]
                                         : key_pool[$urandom_range(0, POOL - 1)];
          queue_op(ACT_DRIVE, k, 16'($urandom), pick_gap(busy));
        end
        queue_op(ACT_TICK, $urandom, pick_elapsed(), pick_gap(busy));
        random_sent += n + 1;
      end else if (style < 92) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          queue_op($urandom_range(0, 1) ? ACT_TICK : ACT_DRIVE, $urandom, pick_elapsed(),
                   pick_gap(busy));
        end
        random_sent += n;
      end else begin
        k = key_pool[$urandom_range(0, POOL - 1)];
        repeat (3) queue_op(ACT_DRIVE, k, 16'($urandom), pick_gap(busy));
        random_sent += 3;
      end
    end

    // age one entry over many full ticks and evict it afterward
    calm_from = queued_items.size();
    drain_next = 1'b1;
    sat_key = $urandom;
    queue_op(ACT_DRIVE, sat_key, 16'($urandom), 0);
    repeat (SAT_TICKS) begin
      queue_op(ACT_TICK, $urandom, 16'hFFFF, 0);
      queue_op(ACT_DRIVE, sat_key, 16'($urandom), 0);
    end
    queue_op(ACT_TICK, $urandom, 16'h0000, 1);
    queue_op(ACT_DRIVE, sat_key, 16'h0, 0);
    for (int i = 1; i <= SLOTS; i++) begin
      queue_op(ACT_DRIVE, sat_key + 32'(i), 16'h0, pick_gap(1'b0));
    end
    queue_op(ACT_TICK, $urandom, pick_elapsed(), 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (queued_items.size() != 0 || req_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d ticks, %0d clamped ages), %0d results checked.",
             ops_accepted, n_ticks, n_clamps, results_seen);
    $display("Drives: %0d hits, %0d fresh claims, %0d evictions of a full table.",
             n_hits, n_claims, n_evicts);
    if (mismatches == 0) begin
      $display("keyed_slot_table_oldest_evict_core_tb OK");
    end else begin
      $display("keyed_slot_table_oldest_evict_core_tb NOT OK");
    end
    $finish;
  end

endmodule
